// ===== hdl/uc_pkg.sv =====
// Package for the UTF-8 codec: queue entry type, constants and byte helpers.
`default_nettype none
package uc_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic KIND_DECODE = 1'b0;
  localparam logic KIND_ENCODE = 1'b1;

  localparam logic CMD_DECODE = 1'b0;

  localparam logic [31:0] LIM_1 = 32'h0000_007f;
  localparam logic [31:0] LIM_2 = 32'h0000_07ff;
  localparam logic [31:0] LIM_3 = 32'h0000_ffff;
  localparam logic [31:0] LIM_4 = 32'h001f_ffff;
  localparam logic [31:0] LIM_5 = 32'h03ff_ffff;

  localparam logic [7:0] CONT_MARK = 8'h80;
  localparam logic [7:0] CONT_MASK = 8'h3f;

  // One transaction handed from the classifier to the serializer.
  typedef struct packed {
    logic        encode;
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        mark;
  } uc_entry_t;

  function automatic logic [2:0] enc_length(input logic [31:0] cp);
    logic [2:0] n;
    if (cp[31] || cp <= LIM_1)  n = 3'd1;
    else if (cp <= LIM_2)       n = 3'd2;
    else if (cp <= LIM_3)       n = 3'd3;
    else if (cp <= LIM_4)       n = 3'd4;
    else if (cp <= LIM_5)       n = 3'd5;
    else                        n = 3'd6;
    return n;
  endfunction

  function automatic logic [7:0] lead_byte(input logic [2:0] n, input logic [7:0] bits);
    logic [7:0] b;
    unique case (n)
      3'd2:    b = 8'hc0 | (bits & 8'h1f);
      3'd3:    b = 8'he0 | (bits & 8'h0f);
      3'd4:    b = 8'hf0 | (bits & 8'h07);
      3'd5:    b = 8'hf8 | (bits & 8'h03);
      3'd6:    b = 8'hfc | (bits & 8'h01);
      default: b = bits;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/uc_front.sv =====
// Front end: accepts items, runs the decode state, classifies encodes.
`default_nettype none
module uc_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             command,
  input  wire logic [31:0]      data_in,
  input  wire logic             last_in,
  input  wire logic             q_full,
  output logic                  push,
  output uc_pkg::uc_entry_t     push_entry
);
  import uc_pkg::*;

  logic [2:0]  pending, pending_next;
  logic [30:0] acc, acc_next;
  logic        emit;
  logic [7:0]  b;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign b        = data_in[7:0];

  always_comb begin
    pending_next      = pending;
    acc_next          = acc;
    emit              = 1'b0;
    push_entry.encode = KIND_ENCODE;
    push_entry.data   = data_in;
    push_entry.nbytes = enc_length(data_in);
    push_entry.mark   = last_in;
    if (command == CMD_DECODE) begin
      push_entry.encode = KIND_DECODE;
      push_entry.nbytes = 3'd1;
      push_entry.data   = {24'd0, b};
      if (pending != 3'd0) begin
        acc_next        = {acc[24:0], b[5:0]};
        pending_next    = pending - 3'd1;
        emit            = (pending == 3'd1);
        push_entry.data = {1'b0, acc_next};
      end else begin
        priority casez (b)
          8'b0???????: emit = 1'b1;
          8'b110?????: begin acc_next = {26'd0, b[4:0]}; pending_next = 3'd1; end
          8'b1110????: begin acc_next = {27'd0, b[3:0]}; pending_next = 3'd2; end
          8'b11110???: begin acc_next = {28'd0, b[2:0]}; pending_next = 3'd3; end
          8'b111110??: begin acc_next = {29'd0, b[1:0]}; pending_next = 3'd4; end
          8'b1111110?: begin acc_next = {30'd0, b[0]};   pending_next = 3'd5; end
          default:     emit = 1'b1;
        endcase
      end
    end else begin
      emit = 1'b1;
    end
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 3'd0;
      acc     <= 31'd0;
    end else if (accept && command == CMD_DECODE) begin
      pending <= pending_next;
      acc     <= acc_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/uc_fifo.sv =====
// Short queue between the front end and the serializer.
`default_nettype none
module uc_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire uc_pkg::uc_entry_t push_entry,
  output logic                   full,
  input  wire logic              pop,
  output logic                   head_valid,
  output uc_pkg::uc_entry_t      head
);
  import uc_pkg::*;

  uc_entry_t         slots [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr, rd_ptr;
  logic [QCntW-1:0]  count;

  assign full       = (count == QCntW'(QueueDepth));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPtrW'(1);
      if (pop)  rd_ptr <= rd_ptr + QPtrW'(1);
      unique case ({push, pop})
        2'b10:   count <= count + QCntW'(1);
        2'b01:   count <= count - QCntW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/uc_back.sv =====
// Back end: holds one entry and emits its results one per cycle while out_ready is high.
`default_nettype none
module uc_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  wire uc_pkg::uc_entry_t head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   kind,
  output logic [31:0]            data_out,
  output logic                   last,
  output logic                   string_end
);
  import uc_pkg::*;

  uc_entry_t   cur;
  logic        cur_valid;
  logic [2:0]  rem;
  logic [31:0] shifted;
  logic        done;

  assign done = out_valid && out_ready && (rem == 3'd0);
  assign pop  = head_valid && (!cur_valid || done);

  always_comb begin
    unique case (rem)
      3'd1:    shifted = cur.data >> 6;
      3'd2:    shifted = cur.data >> 12;
      3'd3:    shifted = cur.data >> 18;
      3'd4:    shifted = cur.data >> 24;
      3'd5:    shifted = cur.data >> 30;
      default: shifted = cur.data;
    endcase
  end

  assign out_valid  = cur_valid;
  assign kind       = cur.encode;
  assign last       = (rem == 3'd0);
  assign string_end = last && cur.mark;

  always_comb begin
    if (cur.encode == KIND_DECODE)       data_out = cur.data;
    else if (cur.nbytes == 3'd1)         data_out = {24'd0, cur.data[7:0]};
    else if (rem == cur.nbytes - 3'd1)   data_out = {24'd0, lead_byte(cur.nbytes, shifted[7:0])};
    else                                 data_out = {24'd0, CONT_MARK | (shifted[7:0] & CONT_MASK)};
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      rem       <= 3'd0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      rem       <= head.nbytes - 3'd1;
    end else if (done) begin
      cur_valid <= 1'b0;
    end else if (out_valid && out_ready) begin
      rem <= rem - 3'd1;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/utf8_codec.sv =====
// Top level of the streaming UTF-8 codec (six-byte form).
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------
//  input    | in_valid/in_ready  | command, data_in[31:0], last_in
//  output   | out_valid/out_ready| kind, data_out[31:0], last, string_end
//
// One input transaction per cycle while the 4-entry queue has room.
// Decode bytes finish in the front end; an encode yields 1 to 6 output
// transactions, one per cycle from the serializer while out_ready is high.
// The first result passes the queue slot and then the serializer register before out_valid rises.
// Sync reset clears decode state, queue and serializer.
// Output stalls fill the queue and then drop in_ready, which also holds the decode state.
`default_nettype none
module utf8_codec (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        command,
  input  wire logic [31:0] data_in,
  input  wire logic        last_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             kind,
  output logic [31:0]      data_out,
  output logic             last,
  output logic             string_end
);
  import uc_pkg::*;

  logic      push, q_full, pop, head_valid;
  uc_entry_t push_entry, head;

  uc_front u_front (
    .clk, .rst, .in_valid, .in_ready, .command, .data_in, .last_in,
    .q_full, .push, .push_entry
  );

  uc_fifo u_fifo (
    .clk, .rst, .push, .push_entry, .full(q_full), .pop, .head_valid, .head
  );

  uc_back u_back (
    .clk, .rst, .head_valid, .head, .pop, .out_valid, .out_ready,
    .kind, .data_out, .last, .string_end
  );

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) q_full |-> !push)
    else $error("push into full queue");
  a_decode_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_DECODE |-> last && !data_out[31])
    else $error("decode result not single or too wide");
  a_end_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_end |-> last)
    else $error("string_end without last");
  a_byte_width: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ENCODE |-> data_out[31:8] == 24'd0)
    else $error("encoded byte wider than 8 bits");
`endif

endmodule
`default_nettype wire
